[rtl/rprs_pkg.sv]
package rprs_pkg;

   localparam int NUM_LEGS       = 4;
   localparam int JOINTS_PER_LEG = 3;
   localparam int NUM_JOINTS     = NUM_LEGS * JOINTS_PER_LEG;
   localparam int NUM_POSES      = 3;
   localparam int JW             = $clog2(NUM_JOINTS);
   localparam int TAW            = $clog2(NUM_POSES * NUM_JOINTS);

   localparam int ANGLE_W    = 16;
   localparam int TICK_W     = 16;
   localparam int HEIGHT_W   = 12;
   localparam int JOINT_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_ENTER = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_FOLD  = 2'd0,
      MODE_STAND = 2'd1,
      MODE_ROLL  = 2'd2
   } mode_type;

   localparam logic [1:0] SEL_START = 2'd0;
   localparam logic [1:0] SEL_FOLD  = 2'd1;
   localparam logic [1:0] SEL_STAND = 2'd2;
   localparam logic [1:0] SEL_ROLL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STAND_RAMP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_RAMP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_SETTLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_RAMP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_SETTLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_HIGH = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_MATH,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MUL,
      PH_DIV
   } phase_type;

   // Q4.12 base angles per joint of a leg (hip, thigh, knee)
   function automatic logic signed [ANGLE_W-1:0] base_angle(
      input logic [1:0] pose, input int j, input logic odd_leg);
      logic signed [ANGLE_W-1:0] v;
      v = '0;
      case (pose)
         MODE_FOLD: begin
            if (j == 1) v = -16'sd5734;
            else if (j == 2) v = 16'sd11059;
         end
         MODE_STAND: begin
            if (j == 1) v = -16'sd3482;
            else if (j == 2) v = 16'sd6758;
         end
         MODE_ROLL: begin
            if (odd_leg) begin
               if (j == 0) v = 16'sd5325;
               else if (j == 1) v = -16'sd14336;
               else if (j == 2) v = 16'sd4096;
            end else begin
               if (j == 0) v = 16'sd6144;
               else if (j == 1) v = -16'sd6554;
               else if (j == 2) v = 16'sd11346;
            end
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] tgt_reset(
      input logic [1:0] pose, input logic [JW-1:0] joint);
      logic signed [ANGLE_W-1:0] v;
      v = '0;
      for (int leg = 0; leg < NUM_LEGS; leg++) begin
         for (int j = 0; j < JOINTS_PER_LEG; j++) begin
            if (joint == JW'(leg * JOINTS_PER_LEG + j))
               v = base_angle(pose, j, leg[0]);
         end
      end
      return v;
   endfunction

endpackage

[rtl/rprs_pose_store.sv]
module rprs_pose_store (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start_we,
   input  logic [rprs_pkg::JW-1:0]            start_waddr,
   input  logic [rprs_pkg::ANGLE_W-1:0]       start_wdata,
   input  logic                               tgt_we,
   input  logic [1:0]                         tgt_wpose,
   input  logic [rprs_pkg::JW-1:0]            tgt_wjoint,
   input  logic [rprs_pkg::ANGLE_W-1:0]       tgt_wdata,
   input  logic [1:0]                         rd_pose,
   input  logic [rprs_pkg::JW-1:0]            rd_joint,
   output logic [rprs_pkg::ANGLE_W-1:0]       start_q,
   output logic [rprs_pkg::ANGLE_W-1:0]       tgt_q
);

   localparam int TDEPTH = rprs_pkg::NUM_POSES * rprs_pkg::NUM_JOINTS;

   logic [rprs_pkg::ANGLE_W-1:0] start_mem [rprs_pkg::NUM_JOINTS];
   logic [rprs_pkg::ANGLE_W-1:0] tgt_mem   [TDEPTH];
   logic [TDEPTH-1:0]            tgt_valid_ff;

   logic [rprs_pkg::ANGLE_W-1:0] tgt_ram_ff;
   logic                         tgt_hit_ff;
   logic [1:0]                   rd_pose_ff;
   logic [rprs_pkg::JW-1:0]      rd_joint_ff;
   logic [rprs_pkg::TAW-1:0]     waddr;
   logic [rprs_pkg::TAW-1:0]     raddr;

   assign waddr = rprs_pkg::TAW'(tgt_wpose) * rprs_pkg::TAW'(rprs_pkg::NUM_JOINTS)
                + rprs_pkg::TAW'(tgt_wjoint);
   assign raddr = rprs_pkg::TAW'(rd_pose) * rprs_pkg::TAW'(rprs_pkg::NUM_JOINTS)
                + rprs_pkg::TAW'(rd_joint);

   always_ff @(posedge clock) begin
      if (start_we) start_mem[start_waddr] <= start_wdata;
      start_q <= start_mem[rd_joint];
   end

   always_ff @(posedge clock) begin
      if (tgt_we) tgt_mem[waddr] <= tgt_wdata;
      tgt_ram_ff  <= tgt_mem[raddr];
      rd_pose_ff  <= rd_pose;
      rd_joint_ff <= rd_joint;
   end

   // valid bits: an entry never written reads as its power-on pose
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_valid_ff <= '0;
         tgt_hit_ff   <= 1'b0;
      end else begin
         if (tgt_we) tgt_valid_ff[waddr] <= 1'b1;
         tgt_hit_ff <= tgt_valid_ff[raddr];
      end
   end

   assign tgt_q = tgt_hit_ff ? tgt_ram_ff : rprs_pkg::tgt_reset(rd_pose_ff, rd_joint_ff);

endmodule

[rtl/rprs_serial_interp.sv]
module rprs_serial_interp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rprs_pkg::ANGLE_W-1:0]     mag,
   input  logic [rprs_pkg::TICK_W-1:0]      count,
   input  logic [rprs_pkg::TICK_W-1:0]      ramp,
   output logic                             done,
   output logic [rprs_pkg::ANGLE_W-1:0]     quot
);

   localparam int PW = 2 * rprs_pkg::TICK_W;
   localparam int CW = $clog2(PW);

   rprs_pkg::phase_type         phase_ff, phase_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        done_ff, done_in;
   logic [PW-1:0]               acc_ff, acc_in;
   logic [rprs_pkg::TICK_W-1:0] rem_ff, rem_in;
   logic [rprs_pkg::ANGLE_W-1:0] mag_ff, mag_in;
   logic [rprs_pkg::TICK_W-1:0] ramp_ff, ramp_in;

   logic [rprs_pkg::TICK_W:0]   msum;
   logic [rprs_pkg::TICK_W:0]   shifted;
   logic                        ge;

   // multiply: shift-add, one multiplier bit per cycle, product in acc
   // divide: restoring, one quotient bit per cycle, quotient back into acc
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      mag_in   = mag_ff;
      ramp_in  = ramp_ff;
      msum     = {1'b0, acc_ff[PW-1:rprs_pkg::TICK_W]}
               + (acc_ff[0] ? {1'b0, mag_ff} : '0);
      shifted  = {rem_ff, acc_ff[PW-1]};
      ge       = shifted >= {1'b0, ramp_ff};
      unique case (phase_ff)
         rprs_pkg::PH_IDLE: begin
            if (start) begin
               phase_in = rprs_pkg::PH_MUL;
               cnt_in   = '0;
               acc_in   = {{rprs_pkg::TICK_W{1'b0}}, count};
               mag_in   = mag;
               ramp_in  = ramp;
            end
         end
         rprs_pkg::PH_MUL: begin
            acc_in = {msum, acc_ff[rprs_pkg::TICK_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(rprs_pkg::TICK_W - 1)) begin
               phase_in = rprs_pkg::PH_DIV;
               cnt_in   = '0;
               rem_in   = '0;
            end
         end
         rprs_pkg::PH_DIV: begin
            // remainder stays below ramp, so it fits TICK_W bits
            rem_in = ge ? rprs_pkg::TICK_W'(shifted - {1'b0, ramp_ff})
                        : shifted[rprs_pkg::TICK_W-1:0];
            acc_in = {acc_ff[PW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(PW - 1)) begin
               phase_in = rprs_pkg::PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: phase_in = rprs_pkg::PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rprs_pkg::PH_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      mag_ff  <= mag_in;
      ramp_ff <= ramp_in;
   end

   assign done = done_ff;
   assign quot = acc_ff[rprs_pkg::ANGLE_W-1:0];

endmodule

[rtl/recovery_pose_ramp_sequencer.sv]
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    operation, pose_select, joint_index,
//                                        joint_angle, body_height_mm, upside_down
// rsp      out        rsp_valid/stall    setpoint_joint, setpoint_angle,
//                                        motion_mode, last_of_tick
// csr      in         csr_we             csr_index, csr_wdata (write only)
//
// Load and enter transactions complete when accepted. A tick emits one setpoint per
// joint in turn: read and prepare, then, on a joint still ramping, a serial
// multiply, a serial divide and a step to pick up the result, then a hand-off;
// a joint whose ramp is finished skips the multiply and divide.
// Synchronous reset restores config, mode and target poses; no clearing pass.
// rsp_stall holds the output register and sequencer; req_stall is high in a tick.
module recovery_pose_ramp_sequencer (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic [1:0]                          req_pose_select,
   input  logic [rprs_pkg::JOINT_W-1:0]        req_joint_index,
   input  logic signed [rprs_pkg::ANGLE_W-1:0] req_joint_angle,
   input  logic [rprs_pkg::HEIGHT_W-1:0]       req_body_height_mm,
   input  logic                                req_upside_down,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rprs_pkg::JOINT_W-1:0]        rsp_setpoint_joint,
   output logic signed [rprs_pkg::ANGLE_W-1:0] rsp_setpoint_angle,
   output logic [1:0]                          rsp_motion_mode,
   output logic                                rsp_last_of_tick,

   input  logic                                csr_we,
   input  logic [rprs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rprs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int TW = rprs_pkg::TICK_W;
   localparam int AW = rprs_pkg::ANGLE_W;
   localparam int HW = rprs_pkg::HEIGHT_W;

   // configuration
   logic [TW-1:0] stand_ramp_ff, fold_ramp_ff, fold_settle_ff;
   logic [TW-1:0] roll_ramp_ff, roll_settle_ff;
   logic [HW-1:0] height_low_ff, height_high_ff;

   // sequencer state
   rprs_pkg::seq_state_type state_ff, state_in;
   rprs_pkg::mode_type      mode_ff, mode_in;
   rprs_pkg::mode_type      tick_mode_ff, tick_mode_in;
   rprs_pkg::mode_type      next_mode_ff, next_mode_in;
   logic [TW-1:0]           ticks_ff, ticks_in;
   logic [TW-1:0]           count_ff, count_in;
   logic [TW-1:0]           ramp_ff, ramp_in;
   logic                    settle_ff, settle_in;
   logic [rprs_pkg::JW-1:0] k_ff, k_in;
   logic [AW-1:0]           result_ff, result_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [rprs_pkg::JOINT_W-1:0] rsp_joint_ff;
   logic [AW-1:0]           rsp_angle_ff;
   logic [1:0]              rsp_mode_ff;
   logic                    rsp_last_ff;
   logic                    rsp_load;

   // store / serial unit hookup
   logic          accept;
   logic          load_valid;
   logic          start_we;
   logic [rprs_pkg::JW-1:0] start_waddr;
   logic [AW-1:0] start_wdata;
   logic          tgt_we;
   logic [AW-1:0] start_q, tgt_q;
   logic          unit_start, unit_done;
   logic [AW-1:0] unit_quot;

   logic [AW:0]   diff;
   logic [AW-1:0] diff_neg;
   logic [AW-1:0] mag;
   logic [AW-1:0] step;
   logic          bypass;
   logic [TW:0]   fold_limit, roll_limit;
   logic          last_joint;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != rprs_pkg::ST_IDLE);
   assign load_valid = accept && (rprs_pkg::op_type'(req_operation) == rprs_pkg::OP_LOAD)
                     && (req_joint_index < rprs_pkg::JOINT_W'(rprs_pkg::NUM_JOINTS));
   assign tgt_we     = load_valid && (req_pose_select != rprs_pkg::SEL_START);

   // difference target minus start, split into sign and magnitude
   assign diff     = {tgt_q[AW-1], tgt_q} - {start_q[AW-1], start_q};
   assign diff_neg = AW'(-diff);
   assign mag      = diff[AW] ? diff_neg : diff[AW-1:0];
   assign step     = diff[AW] ? -unit_quot : unit_quot;
   assign bypass   = (ramp_ff == '0) || (count_ff >= ramp_ff);

   assign fold_limit = {1'b0, fold_ramp_ff} + {1'b0, fold_settle_ff};
   assign roll_limit = {1'b0, roll_ramp_ff} + {1'b0, roll_settle_ff};
   assign last_joint = (k_ff == rprs_pkg::JW'(rprs_pkg::NUM_JOINTS - 1));

   rprs_pose_store u_store (
      .clock       (clock),
      .reset       (reset),
      .start_we    (start_we),
      .start_waddr (start_waddr),
      .start_wdata (start_wdata),
      .tgt_we      (tgt_we),
      .tgt_wpose   (req_pose_select - 2'd1),
      .tgt_wjoint  (rprs_pkg::JW'(req_joint_index)),
      .tgt_wdata   (req_joint_angle),
      .rd_pose     (tick_mode_ff),
      .rd_joint    (k_ff),
      .start_q     (start_q),
      .tgt_q       (tgt_q)
   );

   rprs_serial_interp u_interp (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .mag   (mag),
      .count (count_ff),
      .ramp  (ramp_ff),
      .done  (unit_done),
      .quot  (unit_quot)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      tick_mode_in = tick_mode_ff;
      next_mode_in = next_mode_ff;
      ticks_in     = ticks_ff;
      count_in     = count_ff;
      ramp_in      = ramp_ff;
      settle_in    = settle_ff;
      k_in         = k_ff;
      result_in    = result_ff;
      unit_start   = 1'b0;
      rsp_load     = 1'b0;
      start_we     = load_valid && (req_pose_select == rprs_pkg::SEL_START);
      start_waddr  = rprs_pkg::JW'(req_joint_index);
      start_wdata  = req_joint_angle;

      unique case (state_ff)
         rprs_pkg::ST_IDLE: begin
            if (accept) begin
               case (rprs_pkg::op_type'(req_operation))
                  rprs_pkg::OP_ENTER: begin
                     if (!req_upside_down && (height_low_ff < req_body_height_mm)
                         && (req_body_height_mm < height_high_ff))
                        mode_in = rprs_pkg::MODE_STAND;
                     else
                        mode_in = rprs_pkg::MODE_FOLD;
                     ticks_in = '0;
                  end
                  rprs_pkg::OP_TICK: begin
                     tick_mode_in = mode_ff;
                     count_in     = ticks_ff;
                     k_in         = '0;
                     settle_in    = 1'b0;
                     next_mode_in = rprs_pkg::MODE_FOLD;
                     case (mode_ff)
                        rprs_pkg::MODE_STAND: ramp_in = stand_ramp_ff;
                        rprs_pkg::MODE_ROLL: begin
                           ramp_in   = roll_ramp_ff;
                           settle_in = {1'b0, ticks_ff} > roll_limit;
                        end
                        default: begin
                           ramp_in      = fold_ramp_ff;
                           settle_in    = {1'b0, ticks_ff} >= fold_limit;
                           next_mode_in = req_upside_down ? rprs_pkg::MODE_ROLL
                                                          : rprs_pkg::MODE_STAND;
                        end
                     endcase
                     state_in = rprs_pkg::ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         // read address settles; registered data appears next cycle
         rprs_pkg::ST_READ: state_in = rprs_pkg::ST_CALC;
         rprs_pkg::ST_CALC: begin
            if (bypass) begin
               result_in = tgt_q;
               state_in  = rprs_pkg::ST_EMIT;
            end else begin
               unit_start = 1'b1;
               state_in   = rprs_pkg::ST_MATH;
            end
         end
         rprs_pkg::ST_MATH: begin
            if (unit_done) begin
               result_in = start_q + step;
               state_in  = rprs_pkg::ST_EMIT;
            end
         end
         rprs_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               // settling: finished target becomes the new start, joint by joint
               if (settle_ff) begin
                  start_we    = 1'b1;
                  start_waddr = k_ff;
                  start_wdata = tgt_q;
               end
               if (last_joint) begin
                  state_in = rprs_pkg::ST_IDLE;
                  if (settle_ff) begin
                     mode_in  = next_mode_ff;
                     ticks_in = '0;
                  end else if (ticks_ff != rprs_pkg::TICK_MAX) begin
                     ticks_in = ticks_ff + 1'b1;
                  end
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = rprs_pkg::ST_READ;
               end
            end
         end
         default: state_in = rprs_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rprs_pkg::ST_IDLE;
         mode_ff        <= rprs_pkg::MODE_FOLD;
         ticks_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         stand_ramp_ff  <= 16'd250;
         fold_ramp_ff   <= 16'd400;
         fold_settle_ff <= 16'd700;
         roll_ramp_ff   <= 16'd150;
         roll_settle_ff <= 16'd150;
         height_low_ff  <= 12'd100;
         height_high_ff <= 12'd450;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               rprs_pkg::CSR_STAND_RAMP:  stand_ramp_ff  <= csr_wdata;
               rprs_pkg::CSR_FOLD_RAMP:   fold_ramp_ff   <= csr_wdata;
               rprs_pkg::CSR_FOLD_SETTLE: fold_settle_ff <= csr_wdata;
               rprs_pkg::CSR_ROLL_RAMP:   roll_ramp_ff   <= csr_wdata;
               rprs_pkg::CSR_ROLL_SETTLE: roll_settle_ff <= csr_wdata;
               rprs_pkg::CSR_HEIGHT_LOW:  height_low_ff  <= csr_wdata[HW-1:0];
               rprs_pkg::CSR_HEIGHT_HIGH: height_high_ff <= csr_wdata[HW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tick_mode_ff <= tick_mode_in;
      next_mode_ff <= next_mode_in;
      count_ff     <= count_in;
      ramp_ff      <= ramp_in;
      settle_ff    <= settle_in;
      k_ff         <= k_in;
      result_ff    <= result_in;
      if (rsp_load) begin
         rsp_joint_ff <= rprs_pkg::JOINT_W'(k_ff);
         rsp_angle_ff <= result_ff;
         rsp_mode_ff  <= tick_mode_ff;
         rsp_last_ff  <= last_joint;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_setpoint_joint = rsp_joint_ff;
   assign rsp_setpoint_angle = rsp_angle_ff;
   assign rsp_motion_mode    = rsp_mode_ff;
   assign rsp_last_of_tick   = rsp_last_ff;

endmodule

[rtl/rprs_checker.sv]
module rprs_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [rprs_pkg::JOINT_W-1:0]      rsp_setpoint_joint,
   input logic [rprs_pkg::ANGLE_W-1:0]      rsp_setpoint_angle,
   input logic [1:0]                        rsp_motion_mode,
   input logic                              rsp_last_of_tick
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_setpoint_angle))
      else $error("stalled setpoint changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("setpoint valid after reset");

   a_joint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_setpoint_joint < rprs_pkg::JOINT_W'(rprs_pkg::NUM_JOINTS))
      else $error("joint out of range");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_tick ==
         (rsp_setpoint_joint == rprs_pkg::JOINT_W'(rprs_pkg::NUM_JOINTS - 1))))
      else $error("last flag not on final joint");

   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_tick && !rsp_stall ##1 rsp_valid
         |-> $stable(rsp_motion_mode))
      else $error("mode changed inside a tick");

endmodule

bind recovery_pose_ramp_sequencer rprs_props u_rprs_props (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_setpoint_joint (rsp_setpoint_joint),
   .rsp_setpoint_angle (rsp_setpoint_angle),
   .rsp_motion_mode    (rsp_motion_mode),
   .rsp_last_of_tick   (rsp_last_of_tick)
);

[verif/rprs_checker.sv]
module rprs_checker
   import rprs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [1:0]                  req_pose_select,
   input  logic [JOINT_W-1:0]          req_joint_index,
   input  logic signed [ANGLE_W-1:0]   req_joint_angle,
   input  logic [HEIGHT_W-1:0]         req_body_height_mm,
   input  logic                        req_upside_down,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [JOINT_W-1:0]          rsp_setpoint_joint,
   input  logic signed [ANGLE_W-1:0]   rsp_setpoint_angle,
   input  logic [1:0]                  rsp_motion_mode,
   input  logic                        rsp_last_of_tick,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   output int                          errors,
   output int                          outstanding
);

   typedef struct packed {
      logic [JOINT_W-1:0]        joint;
      logic signed [ANGLE_W-1:0] angle;
      logic [1:0]                mode;
      logic                      last;
   } setpoint_type;

   setpoint_type setpoint_q[$];

   logic signed [ANGLE_W-1:0] start_angle[NUM_JOINTS];
   logic signed [ANGLE_W-1:0] pose_angle[NUM_POSES*NUM_JOINTS];
   mode_type                  cur_mode;
   logic [TICK_W-1:0]         step_count;
   logic [TICK_W-1:0]         stand_ramp, fold_ramp, fold_settle, roll_ramp, roll_settle;
   logic [HEIGHT_W-1:0]       height_low, height_high;

   assign outstanding = setpoint_q.size();

   function automatic logic signed [ANGLE_W-1:0] ramp_angle(
      logic signed [ANGLE_W-1:0] from, logic signed [ANGLE_W-1:0] to,
      logic [TICK_W-1:0] count, logic [TICK_W-1:0] ramp);
      longint span;
      if (ramp == 0 || count >= ramp) return to;
      span = longint'(to) - longint'(from);
      // signed division in SV truncates toward zero
      return ANGLE_W'(longint'(from) + (span * longint'(count)) / longint'(ramp));
   endfunction

   task automatic init_state();
      // default poses per leg joint (hip, thigh, knee)
      logic signed [ANGLE_W-1:0] fold_j[3], stand_j[3], roll_e[3], roll_o[3];
      fold_j  = '{16'sd0, -16'sd5734, 16'sd11059};
      stand_j = '{16'sd0, -16'sd3482, 16'sd6758};
      roll_e  = '{16'sd6144, -16'sd6554, 16'sd11346};
      roll_o  = '{16'sd5325, -16'sd14336, 16'sd4096};
      for (int leg = 0; leg < NUM_LEGS; leg++) begin
         for (int j = 0; j < JOINTS_PER_LEG; j++) begin
            int k = leg * JOINTS_PER_LEG + j;
            start_angle[k] = '0;
            pose_angle[k] = (j < 3) ? fold_j[j] : '0;
            pose_angle[NUM_JOINTS + k] = (j < 3) ? stand_j[j] : '0;
            pose_angle[2*NUM_JOINTS + k] = (j < 3) ? (leg[0] ? roll_o[j] : roll_e[j]) : '0;
         end
      end
      cur_mode = MODE_FOLD;
      step_count = '0;
      stand_ramp = 16'd250; fold_ramp = 16'd400; fold_settle = 16'd700;
      roll_ramp = 16'd150; roll_settle = 16'd150;
      height_low = 12'd100; height_high = 12'd450;
   endtask

   task automatic run_tick(logic flipped);
      logic [TICK_W-1:0] ramp;
      int base;
      logic done;
      setpoint_type sp;
      ramp = (cur_mode == MODE_STAND) ? stand_ramp :
             (cur_mode == MODE_ROLL) ? roll_ramp : fold_ramp;
      base = int'(cur_mode) * NUM_JOINTS;
      for (int k = 0; k < NUM_JOINTS; k++) begin
         sp.joint = JOINT_W'(k);
         sp.angle = ramp_angle(start_angle[k], pose_angle[base + k], step_count, ramp);
         sp.mode  = cur_mode;
         sp.last  = (k == NUM_JOINTS - 1);
         setpoint_q.push_back(sp);
      end
      done = 1'b0;
      if (cur_mode == MODE_FOLD) begin
         if (int'(step_count) >= int'(fold_ramp) + int'(fold_settle)) begin
            done = 1'b1;
            cur_mode = flipped ? MODE_ROLL : MODE_STAND;
         end
      end else if (cur_mode == MODE_ROLL) begin
         if (int'(step_count) > int'(roll_ramp) + int'(roll_settle)) begin
            done = 1'b1;
            cur_mode = MODE_FOLD;
         end
      end
      if (done) begin
         for (int k = 0; k < NUM_JOINTS; k++) start_angle[k] = pose_angle[base + k];
         step_count = '0;
      end else if (step_count != TICK_MAX) begin
         step_count++;
      end
   endtask

   initial begin
      errors = 0;
      init_state();
   end

   always @(posedge clock) begin
      if (reset) begin
         init_state();
         setpoint_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STAND_RAMP:  stand_ramp  = csr_wdata;
               CSR_FOLD_RAMP:   fold_ramp   = csr_wdata;
               CSR_FOLD_SETTLE: fold_settle = csr_wdata;
               CSR_ROLL_RAMP:   roll_ramp   = csr_wdata;
               CSR_ROLL_SETTLE: roll_settle = csr_wdata;
               CSR_HEIGHT_LOW:  height_low  = csr_wdata[HEIGHT_W-1:0];
               CSR_HEIGHT_HIGH: height_high = csr_wdata[HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_operation)
               OP_LOAD: begin
                  if (req_joint_index < NUM_JOINTS) begin
                     if (req_pose_select == SEL_START)
                        start_angle[req_joint_index] = req_joint_angle;
                     else
                        pose_angle[(int'(req_pose_select) - 1) * NUM_JOINTS
                                   + int'(req_joint_index)] = req_joint_angle;
                  end
               end
               OP_ENTER: begin
                  if (!req_upside_down && height_low < req_body_height_mm
                      && req_body_height_mm < height_high)
                     cur_mode = MODE_STAND;
                  else
                     cur_mode = MODE_FOLD;
                  step_count = '0;
               end
               OP_TICK: run_tick(req_upside_down);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (setpoint_q.size() == 0) begin
               errors++;
               $display("%0t: setpoint with none expected: joint %0d angle %0d",
                        $time, rsp_setpoint_joint, rsp_setpoint_angle);
            end else begin
               setpoint_type want;
               want = setpoint_q.pop_front();
               if (rsp_setpoint_joint !== want.joint) begin
                  errors++;
                  $display("%0t: joint expected %0d actual %0d",
                           $time, want.joint, rsp_setpoint_joint);
               end
               if (rsp_setpoint_angle !== want.angle) begin
                  errors++;
                  $display("%0t: angle (joint %0d) expected %0d actual %0d",
                           $time, want.joint, want.angle, rsp_setpoint_angle);
               end
               if (rsp_motion_mode !== want.mode) begin
                  errors++;
                  $display("%0t: mode expected %0d actual %0d",
                           $time, want.mode, rsp_motion_mode);
               end
               if (rsp_last_of_tick !== want.last) begin
                  errors++;
                  $display("%0t: last flag (joint %0d) expected %0d actual %0d",
                           $time, want.joint, want.last, rsp_last_of_tick);
               end
            end
         end
      end
   end

endmodule

[verif/testbench.sv]
module testbench;
   import rprs_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [1:0]                  req_operation;
   logic [1:0]                  req_pose_select;
   logic [JOINT_W-1:0]          req_joint_index;
   logic signed [ANGLE_W-1:0]   req_joint_angle;
   logic [HEIGHT_W-1:0]         req_body_height_mm;
   logic                        req_upside_down;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [JOINT_W-1:0]          rsp_setpoint_joint;
   logic signed [ANGLE_W-1:0]   rsp_setpoint_angle;
   logic [1:0]                  rsp_motion_mode;
   logic                        rsp_last_of_tick;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;
   int                          errors;
   int                          outstanding;
   int                          cycles;
   int                          burst_left;
   int                          stall_pct;
   int                          stall_left;

   recovery_pose_ramp_sequencer dut (.*);

   rprs_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: sized well above the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Receiver stall: the stall rate changes from one random stretch to the next,
   // including stretches that never stall.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 20;
            2: stall_pct <= 50;
            default: stall_pct <= 85;
         endcase
         stall_left <= $urandom_range(50, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Present one transaction and hold it until accepted. Valid is left high
   // so that back-to-back transactions in a burst need no drop.
   task automatic send(logic [1:0] op, logic [1:0] sel, logic [JOINT_W-1:0] joint,
                       logic [15:0] angle, logic [HEIGHT_W-1:0] height, logic flip);
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_pose_select    <= sel;
      req_joint_index    <= joint;
      req_joint_angle    <= angle;
      req_body_height_mm <= height;
      req_upside_down    <= flip;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // sender bursts: when the burst runs out, idle for a random gap, which may be zero
      if (burst_left == 0) begin
         int gap;
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Drain: hold off until every setpoint is back, then let the sequencer
   // finish any load/enter in flight.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic write_all(int sr, int fr, int fs, int rr, int rs, int hl, int hh);
      write_csr(CSR_STAND_RAMP, CSR_DATA_W'(sr));
      write_csr(CSR_FOLD_RAMP, CSR_DATA_W'(fr));
      write_csr(CSR_FOLD_SETTLE, CSR_DATA_W'(fs));
      write_csr(CSR_ROLL_RAMP, CSR_DATA_W'(rr));
      write_csr(CSR_ROLL_SETTLE, CSR_DATA_W'(rs));
      write_csr(CSR_HEIGHT_LOW, CSR_DATA_W'(hl));
      write_csr(CSR_HEIGHT_HIGH, CSR_DATA_W'(hh));
   endtask

   // Random part: mostly ticks and enters so the mode sequence runs through
   // fold, settle, roll and stand; loads keep the poses moving.
   task automatic random_items(int count, int h_lo, int h_hi);
      int done_items;
      int pick;
      logic [HEIGHT_W-1:0] height;
      done_items = 0;
      while (done_items < count) begin
         pick = $urandom_range(0, 99);
         height = ($urandom_range(0, 1) == 0) ? HEIGHT_W'($urandom)
                : HEIGHT_W'($urandom_range(h_lo, h_hi));
         if (pick < 50) begin
            send(OP_TICK, 2'($urandom), 4'($urandom), 16'($urandom), height,
                 ($urandom_range(0, 2) == 0));
            done_items++;
         end else if (pick < 75) begin
            send(OP_LOAD, 2'($urandom), JOINT_W'($urandom_range(0, 15)), 16'($urandom),
                 height, 1'($urandom));
            if (1) done_items++;
         end else if (pick < 93) begin
            send(OP_ENTER, 2'($urandom), 4'($urandom), 16'($urandom), height,
                 ($urandom_range(0, 3) == 0));
            done_items++;
         end else begin
            // undefined operation, ignored by the block
            send(OP_NONE, 2'($urandom), 4'($urandom), 16'($urandom), height,
                 1'($urandom));
         end
         // now and then wait for the pipeline to empty completely
         if ($urandom_range(0, 29) == 0) drain();
      end
   endtask

   initial begin
      cycles             = 0;
      burst_left         = 0;
      stall_pct          = 0;
      stall_left         = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operation      = OP_LOAD;
      req_pose_select    = SEL_START;
      req_joint_index    = '0;
      req_joint_angle    = '0;
      req_body_height_mm = '0;
      req_upside_down    = 1'b0;
      rsp_stall          = 1'b0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill the whole start pose first so no tick reads an
      // unwritten joint, with both angle extremes present.
      for (int k = 0; k < NUM_JOINTS; k++)
         send(OP_LOAD, SEL_START, JOINT_W'(k),
              (k % 3 == 0) ? 16'h8000 : (k % 3 == 1) ? 16'h7fff : 16'($urandom),
              '0, 1'b0);
      send(OP_LOAD, SEL_FOLD, 4'd11, 16'h7fff, 12'hfff, 1'b1);   // fold target extreme
      send(OP_LOAD, SEL_ROLL, 4'd0, 16'h8000, '0, 1'b0);         // roll target extreme
      send(OP_LOAD, SEL_STAND, 4'd12, 16'h1234, '0, 1'b0);       // joint out of range
      send(OP_LOAD, SEL_STAND, 4'd15, 16'hffff, '0, 1'b0);       // joint out of range
      send(OP_NONE, SEL_ROLL, 4'd15, 16'hffff, 12'hfff, 1'b1);   // undefined operation
      send(OP_TICK, '0, '0, '0, '0, 1'b0);                   // fold, count zero
      send(OP_TICK, '0, '0, '0, '0, 1'b1);
      send(OP_ENTER, '0, '0, '0, 12'd101, 1'b0);             // just above low: stand
      send(OP_TICK, '0, '0, '0, '0, 1'b0);
      send(OP_ENTER, '0, '0, '0, 12'd100, 1'b0);             // at low threshold: fold
      send(OP_ENTER, '0, '0, '0, 12'd449, 1'b1);             // upside down: fold
      send(OP_TICK, '0, '0, '0, 12'hfff, 1'b0);
      send(OP_ENTER, '0, '0, '0, 12'd450, 1'b0);             // at high threshold: fold
      drain();

      // Short ramps and settles: fold -> roll -> fold -> stand all happen.
      write_all(3, 2, 1, 2, 1, 0, 4095);
      random_items(30, 0, 8);
      drain();

      // Extremes: zero ramps and settles, widest heights window closed.
      write_all(0, 0, 0, 0, 0, 4095, 0);
      random_items(20, 4090, 4095);
      drain();

      // Longest stand and fold ramps (integer interpolation over a huge span), a roll ramp
      // of 1 and a narrow stand window around the thresholds.
      write_all(65535, 65535, 65535, 1, 65535, 200, 202);
      random_items(18, 199, 203);
      drain();

      write_all(5, 1, 4, 3, 0, 1000, 3000);
      random_items(17, 998, 1002);
      drain();
      repeat (100) @(posedge clock);

      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
